/* src/tcw_pkg.sv */
// Shared types and constants for the text console writer.
// Used by tcw_ctrl, tcw_dp and text_console_writer_core; depends on nothing.
package tcw_pkg;

    // Screen geometry
    localparam int SCREEN_COLS   = 80;
    localparam int SCREEN_ROWS   = 25;
    localparam int CELL_COUNT    = SCREEN_COLS * SCREEN_ROWS;
    localparam int LAST_ROW_BASE = SCREEN_COLS * (SCREEN_ROWS - 1);
    localparam int ADDR_W        = $clog2(CELL_COUNT);

    // Field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CLR_W  = 8;
    localparam int CELL_W = CHAR_W + CLR_W;

    // Character codes
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

    // Opcodes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes (address bit 2)
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [CHAR_W-1:0] char_code;
        logic [10:0]       cell_index;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CHAR_W-1:0] cell_char;
        logic [CLR_W-1:0]  cell_colour;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_FILL,
        ST_PUT,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic cnt_clr;
        logic cnt_inc;
        logic newline;
        logic copy_we;
        logic fill_we;
        logic fill_zero;
        logic put_we;
        logic rd_en;
        logic rd_idx;
        logic load_result;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       is_newline;
        logic       col_full;
        logic       row_last;
        logic       idx_ok;
        logic       cnt_last;
        logic       copy_end;
    } t_dp_status;

    // Linear cell address of a row and column
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(SCREEN_COLS);
        return base + ADDR_W'(col);
    endfunction

endpackage

/* src/text_console_writer_core.sv */
// Scroll: a 1920-cell copy and an 80-cell last-row fill; clear: a 2000-cell fill.
// Input is taken only in idle, once the previous result has been loaded for output.
// The cell store, with one write port and one read port, walks scroll, fill and
// clear one cell per cycle while input is held off.
// Reset: synchronous active-low; afterwards a pass over every cell zeroes the cell
// store, with input ready low, while configuration writes are still taken.
// Top level of the text console writer: APB colour registers, controller and datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_dp.
module text_console_writer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tcw_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tcw_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tcw_pkg::*;

    logic [3:0] r_fg, r_bg;
    logic       cfg_wr;
    t_dp_cmd    cmd;
    t_dp_status status;

    // Colour registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'd15;
            r_bg <= 4'd0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_FG) r_fg <= pwdata[3:0];
            if (paddr[2] == REG_BG) r_bg <= pwdata[3:0];
        end
    end

    assign prdata = {28'd0, (paddr[2] == REG_BG) ? r_bg : r_fg};

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tcw_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_colour   ({r_bg, r_fg}),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

/* src/tcw_dp.sv */
// Datapath of the text console writer: cell store, cursor, sweep counter,
// and result register. Depends on tcw_pkg; driven by tcw_ctrl.
module tcw_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_dp_cmd   i_cmd,
    input  tcw_pkg::t_in_item  i_in_data,
    input  logic [7:0]         i_colour,
    output tcw_pkg::t_dp_status o_status,
    output tcw_pkg::t_out_item o_out_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELL_COUNT];

    logic [1:0]        r_op;
    logic [CHAR_W-1:0] r_char;
    logic [10:0]       r_idx;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [CELL_W-1:0] r_rd_q;
    t_out_item         r_result;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [CELL_W-1:0] wdata;
    logic              cell_hit;

    // Status toward the controller
    always_comb begin
        o_status.op         = r_op;
        o_status.is_newline = (r_char == NEWLINE_CHAR);
        o_status.col_full   = (r_col >= COL_W'(SCREEN_COLS));
        o_status.row_last   = (r_row == ROW_W'(SCREEN_ROWS - 1));
        o_status.idx_ok     = (r_idx < 11'(CELL_COUNT));
        o_status.cnt_last   = (r_cnt == ADDR_W'(CELL_COUNT - 1));
        o_status.copy_end   = (r_cnt == ADDR_W'(LAST_ROW_BASE));
    end

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_in_data.opcode;
            r_char <= i_in_data.char_code;
            r_idx  <= i_in_data.cell_index;
        end
    end

    // Advance cursor and sweep counter
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_cnt = r_cnt;
        if (i_cmd.newline) begin
            n_col = '0;
            if (!o_status.row_last) begin
                n_row = r_row + ROW_W'(1);
            end
        end else if (i_cmd.put_we) begin
            n_col = r_col + COL_W'(1);
        end
        if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_cnt <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_cnt <= n_cnt;
        end
    end

    // Select the store write port
    always_comb begin
        we = i_cmd.put_we | i_cmd.copy_we | i_cmd.fill_we;
        priority if (i_cmd.put_we) begin
            waddr = cell_addr(r_row, r_col);
            wdata = {i_colour, r_char};
        end else if (i_cmd.copy_we) begin
            waddr = r_cnt - ADDR_W'(1);
            wdata = r_rd_q;
        end else begin
            waddr = r_cnt;
            wdata = i_cmd.fill_zero ? '0 : {i_colour, SPACE_CHAR};
        end
        raddr = i_cmd.rd_idx ? r_idx[ADDR_W-1:0] : r_cnt + ADDR_W'(SCREEN_COLS);
    end

    // Cell store, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_q <= mem[raddr];
        end
    end

    // Load the result register
    assign cell_hit = (r_op == OP_READ) && o_status.idx_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_result.cursor_row  <= r_row;
            r_result.cursor_col  <= r_col;
            r_result.cell_char   <= cell_hit ? r_rd_q[CHAR_W-1:0] : '0;
            r_result.cell_colour <= cell_hit ? r_rd_q[CELL_W-1:CHAR_W] : '0;
        end
    end

    assign o_out_data = r_result;

`ifndef SYNTH
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row < ROW_W'(SCREEN_ROWS))
        else $error("cursor row beyond last row");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(SCREEN_COLS))
        else $error("cursor column beyond full mark");
    a_put_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put_we |-> r_col < COL_W'(SCREEN_COLS))
        else $error("put written past end of row");
    a_copy_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_en && !i_cmd.rd_idx) |-> r_cnt < ADDR_W'(LAST_ROW_BASE))
        else $error("scroll source outside store");
`endif

endmodule

/* src/tcw_ctrl.sv */
// Controller state machine of the text console writer: sequences puts,
// scrolls, fills and reads, and owns both handshakes. Depends on tcw_pkg.
module tcw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  tcw_pkg::t_dp_status  i_status,
    output tcw_pkg::t_dp_cmd     o_cmd
);
    import tcw_pkg::*;

    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   r_out_valid, n_out_valid;
    logic   r_copy_primed;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        unique case (r_state)
            ST_INIT: begin
                if (i_status.cnt_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_pend = 1'b0;
                priority if (i_status.op == OP_PUT) begin
                    if (i_status.is_newline) begin
                        n_state = i_status.row_last ? ST_COPY : ST_DONE;
                    end else if (i_status.col_full) begin
                        n_pend  = 1'b1;
                        n_state = i_status.row_last ? ST_COPY : ST_PUT;
                    end else begin
                        n_state = ST_PUT;
                    end
                end else if (i_status.op == OP_CLEAR) begin
                    n_state = ST_FILL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_COPY: begin
                if (i_status.copy_end) n_state = ST_FILL;
            end
            ST_FILL: begin
                if (i_status.cnt_last) n_state = r_pend ? ST_PUT : ST_DONE;
            end
            ST_PUT: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.fill_we   = 1'b1;
                o_cmd.fill_zero = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                o_cmd.cnt_clr = i_in_valid;
            end
            ST_EXEC: begin
                if (i_status.op == OP_PUT) begin
                    o_cmd.newline = i_status.is_newline || i_status.col_full;
                end
                if (i_status.op == OP_READ && i_status.idx_ok) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_idx = 1'b1;
                end
            end
            ST_COPY: begin
                o_cmd.rd_en   = !i_status.copy_end;
                // The first copy step only primes the read register
                o_cmd.copy_we = r_copy_primed;
                o_cmd.cnt_inc = !i_status.copy_end;
            end
            ST_FILL: begin
                o_cmd.fill_we = 1'b1;
                o_cmd.cnt_inc = !i_status.cnt_last;
            end
            ST_PUT: begin
                o_cmd.put_we = 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_out_valid       = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Copy write starts once the read register holds a copied cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_copy_primed <= 1'b0;
        end else begin
            r_copy_primed <= (r_state == ST_COPY) && !i_status.copy_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == ST_IDLE))
        else $error("input taken outside idle");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.put_we, o_cmd.copy_we, o_cmd.fill_we}))
        else $error("two store writes in one cycle");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_result |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before transfer");
    a_pend_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL && i_status.cnt_last && r_pend) |=> (r_state == ST_PUT))
        else $error("wrapped put lost after scroll");
`endif

endmodule

/* test/text_console_writer_core_tb.sv */
// Self-checking testbench for text_console_writer_core: puts, newlines, wraps,
// scrolls, clears and cell reads checked against an in-bench console model.
// Depends on tcw_pkg and the text_console_writer_core RTL.
module text_console_writer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         PHASE_COUNT   = 6;
    localparam int         PHASE_ITEMS   = 200;
    localparam int         LONG_HOLD     = 300;
    localparam int         WATCHDOG_LIMIT = 25000;
    localparam int         DRAIN_CYCLES  = 32;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_data;
    logic       psel = 1'b0;
    logic       penable = 1'b0;
    logic       pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic       pready;

    // Console model state
    logic [CELL_W-1:0] cell_mem [CELL_COUNT];
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [3:0]        fg_reg;
    logic [3:0]        bg_reg;

    t_in_item  pending_q [$];
    t_out_item expected_q [$];
    t_out_item want;

    int   err_count = 0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    logic tail_quiet = 1'b0;
    logic hold_off_armed = 1'b0;
    logic hold_off_done = 1'b0;

    text_console_writer_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Space in the current colour
    function automatic logic [CELL_W-1:0] blank_cell_value();
        return {bg_reg, fg_reg, SPACE_CHAR};
    endfunction

    // Move to column 0 of the next row, scrolling on the last row
    function automatic void next_line();
        cur_col = '0;
        if (int'(cur_row) + 1 < SCREEN_ROWS) begin
            cur_row = cur_row + 1'b1;
        end else begin
            for (int i = 0; i < LAST_ROW_BASE; i++) cell_mem[i] = cell_mem[i + SCREEN_COLS];
            for (int i = LAST_ROW_BASE; i < CELL_COUNT; i++) cell_mem[i] = blank_cell_value();
        end
    endfunction

    // Apply one command to the console model and return the reported result
    function automatic t_out_item console_step(input t_in_item item);
        t_out_item res;
        res = '0;
        case (item.opcode)
            OP_PUT: begin
                if (item.char_code == NEWLINE_CHAR) begin
                    next_line();
                end else begin
                    if (int'(cur_col) >= SCREEN_COLS) next_line();
                    cell_mem[int'(cur_row) * SCREEN_COLS + int'(cur_col)] =
                        {bg_reg, fg_reg, item.char_code};
                    cur_col = cur_col + 1'b1;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++) cell_mem[i] = blank_cell_value();
            end
            OP_READ: begin
                if (int'(item.cell_index) < CELL_COUNT) begin
                    res.cell_char   = cell_mem[int'(item.cell_index)][CHAR_W-1:0];
                    res.cell_colour = cell_mem[int'(item.cell_index)][CELL_W-1:CHAR_W];
                end
            end
            default: ;
        endcase
        res.cursor_row = cur_row;
        res.cursor_col = cur_col;
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
            err_count++;
        end
    endtask

    // Command driver: predict on each input transfer, then offer the next command
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && in_ready) expected_q.push_back(console_step(in_data));
            if (!in_valid || in_ready) begin
                if (send_gap == 0 && !tail_quiet && $urandom_range(0, 7) == 0)
                    send_gap = 1 + $urandom_range(0, 3);
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each output transfer, stall the output at random
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with nothing pending: row %0d col %0d",
                           out_data.cursor_row, out_data.cursor_col);
                    err_count++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("cursor_row", 32'(want.cursor_row),
                                  32'(out_data.cursor_row));
                    compare_field("cursor_col", 32'(want.cursor_col),
                                  32'(out_data.cursor_col));
                    compare_field("cell_char", 32'(want.cell_char),
                                  32'(out_data.cell_char));
                    compare_field("cell_colour", 32'(want.cell_colour),
                                  32'(out_data.cell_colour));
                end
            end
            // hold off once for a long stretch so the block backs up its input
            if (hold_off_armed && !hold_off_done) begin
                hold_off_done = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 3);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing transfers for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_item(input logic [1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [10:0] idx);
        t_in_item entry;
        entry.opcode     = op;
        entry.char_code  = ch;
        entry.cell_index = idx;
        pending_q.push_back(entry);
    endtask

    // Write a colour register over APB and read it back
    task automatic write_colour(input logic reg_sel, input logic [3:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {28'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (reg_sel == REG_FG) fg_reg = value;
        else bg_reg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        compare_field(reg_sel == REG_FG ? "foreground_colour" : "background_colour",
                      32'(value), 32'(prdata[3:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Fill the queue with text lines, blank lines, reads, clears and noise
    task automatic queue_random_phase(input int n_items);
        int start;
        int pick;
        int len;
        int r;
        logic [CHAR_W-1:0] ch;
        logic [10:0] idx;
        start = pending_q.size();
        while (pending_q.size() - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                r = $urandom_range(0, 4);
                if (r < 3) len = $urandom_range(0, 8);
                else if (r == 3) len = $urandom_range(72, 88);
                else len = $urandom_range(0, 79);
                repeat (len) begin
                    ch = 8'($urandom_range(0, 254));
                    if (ch >= NEWLINE_CHAR) ch = ch + 1'b1;
                    queue_item(OP_PUT, ch, 11'($urandom_range(0, 2047)));
                end
                if ($urandom_range(0, 9) != 0)
                    queue_item(OP_PUT, NEWLINE_CHAR, 11'($urandom_range(0, 2047)));
            end else if (pick < 65) begin
                repeat ($urandom_range(1, 4))
                    queue_item(OP_PUT, NEWLINE_CHAR, 11'($urandom_range(0, 2047)));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, 9);
                    if (r == 0) idx = 11'($urandom_range(CELL_COUNT, 2047));
                    else if (r < 5)
                        idx = 11'($urandom_range(LAST_ROW_BASE - 4 * SCREEN_COLS,
                                                 CELL_COUNT - 1));
                    else idx = 11'($urandom_range(0, CELL_COUNT - 1));
                    queue_item(OP_READ, 8'($urandom_range(0, 255)), idx);
                end
            end else if (pick < 88) begin
                queue_item(OP_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                               11'($urandom_range(0, 2047)));
            end
        end
    endtask

    initial begin
        logic [3:0] fg_next;
        logic [3:0] bg_next;

        // reset state of the model
        for (int i = 0; i < CELL_COUNT; i++) cell_mem[i] = '0;
        cur_row = '0;
        cur_col = '0;
        fg_reg  = 4'hF;
        bg_reg  = 4'h0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed commands under the reset colours
        queue_item(OP_READ, 8'h00, 11'd0);
        queue_item(OP_READ, 8'hFF, 11'(CELL_COUNT - 1));
        queue_item(OP_READ, 8'h00, 11'(CELL_COUNT));
        queue_item(OP_READ, 8'hFF, 11'h7FF);
        queue_item(OP_UNUSED, 8'hFF, 11'h7FF);
        queue_item(OP_PUT, 8'h00, 11'd0);
        queue_item(OP_PUT, 8'hFF, 11'h7FF);
        queue_item(OP_PUT, SPACE_CHAR, 11'd0);
        queue_item(OP_READ, 8'h00, 11'd0);
        queue_item(OP_READ, 8'h00, 11'd1);
        queue_item(OP_READ, 8'h00, 11'd2);
        queue_item(OP_PUT, NEWLINE_CHAR, 11'h7FF);
        queue_item(OP_PUT, 8'h41, 11'd0);
        queue_item(OP_READ, 8'h00, 11'(SCREEN_COLS));
        queue_item(OP_CLEAR, 8'hFF, 11'h7FF);
        queue_item(OP_READ, 8'h00, 11'd0);
        queue_item(OP_READ, 8'h00, 11'(CELL_COUNT - 1));
        queue_item(OP_READ, 8'h00, 11'(SCREEN_COLS));
        queue_item(OP_PUT, 8'h7E, 11'd0);
        queue_item(OP_UNUSED, 8'h00, 11'd0);

        // random phases, each under its own colour setting
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_idle();
            case (phase)
                0: begin fg_next = 4'h0; bg_next = 4'h0; end
                1: begin fg_next = 4'hF; bg_next = 4'hF; end
                2: begin fg_next = 4'h0; bg_next = 4'hF; end
                default: begin
                    fg_next = 4'($urandom_range(0, 15));
                    bg_next = 4'($urandom_range(0, 15));
                end
            endcase
            write_colour(REG_FG, fg_next);
            write_colour(REG_BG, bg_next);
            if (phase == 0) hold_off_armed = 1'b1;
            if (phase == PHASE_COUNT - 1) tail_quiet = 1'b1;
            queue_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
